FILE: rtl/core/pei_pkg.sv
package pei_pkg;

    localparam int CW = 16;           // coordinate width, Q12.4
    localparam int FB = 15;           // fraction bits of the cut position
    localparam int BW = CW + 2;       // coordinate differences and box bounds
    localparam int WW = 56;           // cross products, scaled numerators
    localparam int FW = 16;           // cut_fraction field width
    localparam int IW = 3;            // config index width
    localparam int SW = 5;            // sequencer step width
    localparam int DCW = $clog2(FB);

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [BW-1:0] t_bsig;
    typedef logic signed [WW-1:0] t_wide;
    typedef logic [SW-1:0]        t_step;
    typedef logic [DCW-1:0]       t_dcnt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef logic [1:0] t_side;
    localparam t_side SIDE_ZERO = 2'd0;
    localparam t_side SIDE_POS  = 2'd1;
    localparam t_side SIDE_NEG  = 2'd2;

    typedef logic [1:0] t_hit;
    localparam t_hit HIT_NONE  = 2'd0;
    localparam t_hit HIT_START = 2'd1;
    localparam t_hit HIT_END   = 2'd2;

    localparam logic [1:0] MODE_MULTICUT = 2'd2;

    localparam logic [IW-1:0] REG_START_X = 3'd0;
    localparam logic [IW-1:0] REG_START_Y = 3'd1;
    localparam logic [IW-1:0] REG_END_X   = 3'd2;
    localparam logic [IW-1:0] REG_END_Y   = 3'd3;
    localparam logic [IW-1:0] REG_MODE    = 3'd4;

    // sequencer steps
    localparam t_step STEP_S2A   = 5'd0;
    localparam t_step STEP_S2B   = 5'd1;
    localparam t_step STEP_S1A   = 5'd2;
    localparam t_step STEP_S1B   = 5'd3;
    localparam t_step STEP_TEST  = 5'd4;
    localparam t_step STEP_XNA   = 5'd5;
    localparam t_step STEP_XNB   = 5'd6;
    localparam t_step STEP_YNA   = 5'd7;
    localparam t_step STEP_YNB   = 5'd8;
    localparam t_step STEP_XLO   = 5'd9;
    localparam t_step STEP_XHI   = 5'd10;
    localparam t_step STEP_YLO   = 5'd11;
    localparam t_step STEP_YHI   = 5'd12;
    localparam t_step STEP_AX    = 5'd13;
    localparam t_step STEP_AY    = 5'd14;
    localparam t_step STEP_BX    = 5'd15;
    localparam t_step STEP_BY    = 5'd16;
    localparam t_step STEP_SCALE = 5'd17;
    localparam t_step STEP_DEC   = 5'd18;

    function automatic t_side side_of(input t_wide s);
        t_side r;
        if (s == '0) begin
            r = SIDE_ZERO;
        end else if (s > 0) begin
            r = SIDE_POS;
        end else begin
            r = SIDE_NEG;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/pei_ifs.sv
interface pei_point_if import pei_pkg::*; ();
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   last_point;
    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pei_result_if import pei_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [FW-1:0] cut_fraction;
    logic          start_vertex_hit;
    logic          end_vertex_hit;
    modport source (output valid, cut_fraction, start_vertex_hit, end_vertex_hit,
                    input ready);
    modport sink (input valid, cut_fraction, start_vertex_hit, end_vertex_hit,
                  output ready);
endinterface

interface pei_cfg_if import pei_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [IW-1:0] index;
    logic [CW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/pei_mac.sv
module pei_mac import pei_pkg::*; (
    input  t_wide i_a,
    input  t_bsig i_b,
    input  t_wide i_c,
    input  logic  i_sub,
    output t_wide o_p
);
    t_wide prod;

    assign prod = i_a * t_wide'(i_b);
    assign o_p  = i_sub ? (i_c - prod) : (i_c + prod);
endmodule

FILE: rtl/core/polyline_edge_intersect.sv
// A point that cannot cross leaves the sequencer after STEP_TEST; a crossing point runs
// up to 19 sequencer steps on one shared multiply-add, then 15 restoring divide steps
// when its cut is not trivial, then the update state ST_DONE; for the last point the result is registered there.
// Throughput: one point at a time; the next point is taken after ST_DONE, which holds a
// last point until the output register is free. Reset (synchronous, active low) clears
// the edge registers, the trail state and the output valid flag.
module polyline_edge_intersect import pei_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pei_point_if.sink    i_point,
    pei_result_if.source o_result,
    pei_cfg_if.sink      i_cfg
);
    t_state r_state, n_state;
    t_step  r_step;
    t_dcnt  r_dcnt;

    t_coord     r_ax, r_ay, r_bx, r_by;
    logic [1:0] r_mode;

    t_coord r_px, r_py, r_x1, r_y1;
    logic   r_last, r_mc;

    t_coord r_prev_x, r_prev_y;
    t_side  r_prev_side;
    logic   r_pending;
    t_hit   r_exact;
    logic   r_found;
    logic [FW-1:0] r_frac;
    t_hit   r_fvert;

    t_wide r_s1, r_s2, r_den, r_xn, r_yn, r_prod, r_num, r_rem, r_dd;
    logic  r_neg, r_ok, r_eqxa, r_eqya, r_eqxb, r_eqyb;
    logic [FW-1:0] r_q;

    logic r_ovalid;
    logic [FW-1:0] r_o_frac;
    logic r_o_sh, r_o_eh;

    t_bsig ax, ay, bx, by, dx, dy, px, py, x1, y1;
    t_bsig xlo, xhi, ylo, yhi, mx_hi, mx_lo, my_hi, my_lo;
    logic [BW-1:0] adx, ady;
    logic  use_x, cand, out_free, accept, vert_a, vert_b, div_go, div_trivial;
    t_side c1, c2;
    t_wide den_raw, dd_n, num_n, rem2;
    t_wide mac_a, mac_c, mac_p;
    t_bsig mac_b;
    logic  mac_sub;

    assign accept   = i_point.valid && i_point.ready;
    assign out_free = !r_ovalid || o_result.ready;

    assign ax = t_bsig'(r_ax);
    assign ay = t_bsig'(r_ay);
    assign bx = t_bsig'(r_bx);
    assign by = t_bsig'(r_by);
    assign dx = bx - ax;
    assign dy = by - ay;
    assign px = t_bsig'(r_px);
    assign py = t_bsig'(r_py);
    assign x1 = t_bsig'(r_x1);
    assign y1 = t_bsig'(r_y1);
    assign xlo = ((ax < bx) ? ax : bx) - t_bsig'(1);
    assign xhi = ((ax > bx) ? ax : bx) + t_bsig'(1);
    assign ylo = ((ay < by) ? ay : by) - t_bsig'(1);
    assign yhi = ((ay > by) ? ay : by) + t_bsig'(1);
    assign adx = (dx < 0) ? BW'(-dx) : BW'(dx);
    assign ady = (dy < 0) ? BW'(-dy) : BW'(dy);
    assign use_x = ady <= adx;

    // midpoint of the overlap, for a segment parallel to the edge line
    assign mx_hi = (x1 > px) ? x1 : px;
    assign mx_lo = (x1 < px) ? x1 : px;
    assign my_hi = (y1 > py) ? y1 : py;
    assign my_lo = (y1 < py) ? y1 : py;

    assign c2 = side_of(r_s2);
    assign c1 = r_pending ? c2 : r_prev_side;
    assign cand = !r_found && !(dx == '0 && dy == '0) &&
                  (c1 == SIDE_ZERO || c2 == SIDE_ZERO || c1 != c2);
    assign den_raw = r_s1 - r_s2;

    assign vert_a = !r_mc && r_eqxa && r_eqya;
    assign vert_b = !r_mc && !vert_a && r_eqxb && r_eqyb;
    assign dd_n  = (r_prod < 0) ? -r_prod : r_prod;
    assign num_n = (r_prod < 0) ? -r_num : r_num;
    assign div_trivial = (dd_n == '0) || (num_n <= 0) || (num_n >= dd_n);
    assign div_go = r_ok && !vert_a && !vert_b && !div_trivial;
    assign rem2 = r_rem <<< 1;

    always_comb begin
        mac_a   = '0;
        mac_b   = '0;
        mac_c   = '0;
        mac_sub = 1'b0;
        unique case (r_step)
            STEP_S2A: begin
                mac_a = t_wide'(dx);
                mac_b = py - ay;
            end
            STEP_S2B: begin
                mac_a = t_wide'(dy);
                mac_b = px - ax;
                mac_c = r_s2;
                mac_sub = 1'b1;
            end
            STEP_S1A: begin
                mac_a = t_wide'(dx);
                mac_b = y1 - ay;
            end
            STEP_S1B: begin
                mac_a = t_wide'(dy);
                mac_b = x1 - ax;
                mac_c = r_s1;
                mac_sub = 1'b1;
            end
            STEP_XNA: begin
                mac_a = r_den;
                mac_b = x1;
            end
            STEP_XNB: begin
                mac_a = r_s1;
                mac_b = r_neg ? (x1 - px) : (px - x1);
                mac_c = r_xn;
            end
            STEP_YNA: begin
                mac_a = r_den;
                mac_b = y1;
            end
            STEP_YNB: begin
                mac_a = r_s1;
                mac_b = r_neg ? (y1 - py) : (py - y1);
                mac_c = r_yn;
            end
            STEP_XLO: begin
                mac_a = r_den;
                mac_b = xlo;
            end
            STEP_XHI: begin
                mac_a = r_den;
                mac_b = xhi;
            end
            STEP_YLO: begin
                mac_a = r_den;
                mac_b = ylo;
            end
            STEP_YHI: begin
                mac_a = r_den;
                mac_b = yhi;
            end
            STEP_AX: begin
                mac_a = r_den;
                mac_b = ax;
            end
            STEP_AY: begin
                mac_a = r_den;
                mac_b = ay;
            end
            STEP_BX: begin
                mac_a = r_den;
                mac_b = bx;
            end
            STEP_BY: begin
                mac_a = r_den;
                mac_b = by;
            end
            STEP_SCALE: begin
                mac_a = r_den;
                mac_b = use_x ? dx : dy;
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    pei_mac u_mac (
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .i_sub (mac_sub),
        .o_p   (mac_p)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_step == STEP_TEST && !cand) begin
                    n_state = ST_DONE;
                end else if (r_step == STEP_DEC) begin
                    n_state = div_go ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV: begin
                if (r_dcnt == t_dcnt'(FB - 1)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_last || out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_point.ready = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax   <= '0;
            r_ay   <= '0;
            r_bx   <= '0;
            r_by   <= '0;
            r_mode <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_START_X: r_ax <= i_cfg.data;
                REG_START_Y: r_ay <= i_cfg.data;
                REG_END_X:   r_bx <= i_cfg.data;
                REG_END_Y:   r_by <= i_cfg.data;
                REG_MODE:    r_mode <= i_cfg.data[1:0];
                default: ;
            endcase
        end
    end

    // trail state and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_dcnt      <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_side <= SIDE_ZERO;
            r_pending   <= 1'b1;
            r_exact     <= HIT_NONE;
            r_found     <= 1'b0;
            r_frac      <= '0;
            r_fvert     <= HIT_NONE;
            r_last      <= 1'b0;
            r_mc        <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_step <= STEP_S2A;
                        r_last <= i_point.last_point;
                        r_mc   <= (r_mode == MODE_MULTICUT);
                        if (r_mode != MODE_MULTICUT && r_exact == HIT_NONE) begin
                            if (i_point.point_x == r_ax && i_point.point_y == r_ay) begin
                                r_exact <= HIT_START;
                            end else if (i_point.point_x == r_bx &&
                                         i_point.point_y == r_by) begin
                                r_exact <= HIT_END;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    if (r_step == STEP_TEST && r_s1 == r_s2) begin
                        r_step <= STEP_XLO;
                    end else begin
                        r_step <= r_step + t_step'(1);
                    end
                    if (r_step == STEP_DEC && r_ok) begin
                        r_found <= 1'b1;
                        r_frac  <= '0;
                        r_dcnt  <= '0;
                        if (vert_a) begin
                            r_fvert <= HIT_START;
                        end else if (vert_b) begin
                            r_fvert <= HIT_END;
                        end else begin
                            r_fvert <= HIT_NONE;
                            if (dd_n != '0 && num_n > 0 && num_n >= dd_n) begin
                                r_frac <= FW'(1 << FB);
                            end
                        end
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt + t_dcnt'(1);
                    if (r_dcnt == t_dcnt'(FB - 1)) begin
                        r_frac <= {r_q[FW-2:0], (rem2 >= r_dd)};
                    end
                end
                ST_DONE: begin
                    if (!r_last || out_free) begin
                        if (r_last) begin
                            r_prev_x    <= '0;
                            r_prev_y    <= '0;
                            r_prev_side <= SIDE_ZERO;
                            r_pending   <= 1'b1;
                            r_exact     <= HIT_NONE;
                            r_found     <= 1'b0;
                            r_frac      <= '0;
                            r_fvert     <= HIT_NONE;
                        end else begin
                            r_prev_x    <= r_px;
                            r_prev_y    <= r_py;
                            r_prev_side <= c2;
                            r_pending   <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_px <= i_point.point_x;
            r_py <= i_point.point_y;
            r_x1 <= r_pending ? i_point.point_x : r_prev_x;
            r_y1 <= r_pending ? i_point.point_y : r_prev_y;
        end
        if (r_state == ST_CALC) begin
            unique case (r_step)
                STEP_S2A, STEP_S2B: r_s2 <= mac_p;
                STEP_S1A, STEP_S1B: r_s1 <= mac_p;
                STEP_TEST: begin
                    if (r_s1 != r_s2) begin
                        r_neg <= den_raw < 0;
                        r_den <= (den_raw < 0) ? -den_raw : den_raw;
                    end else begin
                        r_den <= t_wide'(2);
                        r_xn  <= t_wide'((xhi < mx_hi) ? xhi : mx_hi) +
                                 t_wide'((xlo > mx_lo) ? xlo : mx_lo);
                        r_yn  <= t_wide'((yhi < my_hi) ? yhi : my_hi) +
                                 t_wide'((ylo > my_lo) ? ylo : my_lo);
                    end
                end
                STEP_XNA, STEP_XNB: r_xn <= mac_p;
                STEP_YNA, STEP_YNB: r_yn <= mac_p;
                STEP_XLO: begin
                    r_ok   <= 1'b1;
                    r_prod <= mac_p;
                end
                STEP_XHI: begin
                    r_ok   <= r_ok && (r_xn >= r_prod);
                    r_prod <= mac_p;
                end
                STEP_YLO: begin
                    r_ok   <= r_ok && (r_xn <= r_prod);
                    r_prod <= mac_p;
                end
                STEP_YHI: begin
                    r_ok   <= r_ok && (r_yn >= r_prod);
                    r_prod <= mac_p;
                end
                STEP_AX: begin
                    r_ok   <= r_ok && (r_yn <= r_prod);
                    r_prod <= mac_p;
                end
                STEP_AY: begin
                    r_eqxa <= (r_xn == r_prod);
                    if (use_x) r_num <= r_xn - r_prod;
                    r_prod <= mac_p;
                end
                STEP_BX: begin
                    r_eqya <= (r_yn == r_prod);
                    if (!use_x) r_num <= r_yn - r_prod;
                    r_prod <= mac_p;
                end
                STEP_BY: begin
                    r_eqxb <= (r_xn == r_prod);
                    r_prod <= mac_p;
                end
                STEP_SCALE: begin
                    // compare y against by*den before the scale product lands
                    r_eqyb <= (r_yn == r_prod);
                    r_prod <= mac_p;
                end
                STEP_DEC: begin
                    r_rem <= num_n;
                    r_dd  <= dd_n;
                    r_q   <= '0;
                end
                default: ;
            endcase
        end
        if (r_state == ST_DIV) begin
            if (rem2 >= r_dd) begin
                r_rem <= rem2 - r_dd;
                r_q   <= {r_q[FW-2:0], 1'b1};
            end else begin
                r_rem <= rem2;
                r_q   <= {r_q[FW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == ST_DONE && r_last && out_free) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && r_last && out_free) begin
            if (r_exact != HIT_NONE) begin
                r_o_frac <= '0;
                r_o_sh   <= (r_exact == HIT_START);
                r_o_eh   <= (r_exact == HIT_END);
            end else if (r_found) begin
                r_o_frac <= r_frac;
                r_o_sh   <= (r_fvert == HIT_START);
                r_o_eh   <= (r_fvert == HIT_END);
            end else begin
                r_o_frac <= '0;
                r_o_sh   <= 1'b0;
                r_o_eh   <= 1'b0;
            end
        end
    end

    assign o_result.valid            = r_ovalid;
    assign o_result.cut_fraction     = r_o_frac;
    assign o_result.start_vertex_hit = r_o_sh;
    assign o_result.end_vertex_hit   = r_o_eh;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_CALC && r_step == STEP_S2A))
        else $error("accepted point did not start the sequencer");

    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.start_vertex_hit && o_result.end_vertex_hit))
        else $error("both vertex hits reported");

    a_hit_no_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.start_vertex_hit || o_result.end_vertex_hit))
        |-> (o_result.cut_fraction == '0))
        else $error("vertex hit with nonzero cut");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac <= FW'(1 << FB))
        else $error("cut fraction out of range");
`endif

endmodule
